// ===== hdl/sccr_pkg.sv =====
// Shared types and constants for the streaming covariance / correlation block.
// Holds the channel payload structs, controller commands and status codes.
// No dependencies.
package sccr_pkg;

  localparam int unsigned CfgIdxW = 3;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_MEAN_X = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_MEAN_Y = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_X_POP  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_Y_POP  = 3'd3;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FEW      = 2'd1;
  localparam logic [1:0] ST_ZERO_VAR = 2'd2;

  // Multiplier operand selects
  localparam logic [2:0] MUL_XY  = 3'd0;
  localparam logic [2:0] MUL_XX  = 3'd1;
  localparam logic [2:0] MUL_YY  = 3'd2;
  localparam logic [2:0] MUL_P00 = 3'd3;
  localparam logic [2:0] MUL_P01 = 3'd4;
  localparam logic [2:0] MUL_P10 = 3'd5;
  localparam logic [2:0] MUL_P11 = 3'd6;

  // Accumulator update selects
  localparam logic [1:0] ACC_NONE  = 2'd0;
  localparam logic [1:0] ACC_CROSS = 2'd1;
  localparam logic [1:0] ACC_SQX   = 2'd2;
  localparam logic [1:0] ACC_SQY   = 2'd3;

  // Radicand build operations
  localparam logic [1:0] RAD_NONE  = 2'd0;
  localparam logic [1:0] RAD_LOAD  = 2'd1;
  localparam logic [1:0] RAD_ADD32 = 2'd2;
  localparam logic [1:0] RAD_ADD64 = 2'd3;

  // Divider source selects
  localparam logic [1:0] DIV_CROSS = 2'd0;
  localparam logic [1:0] DIV_SQX   = 2'd1;
  localparam logic [1:0] DIV_SQY   = 2'd2;

  localparam logic [62:0] VarMax = {63{1'b1}};

  typedef struct packed {
    logic signed [31:0] sample_x;
    logic signed [31:0] sample_y;
    logic               last_sample;
  } in_t;

  typedef struct packed {
    logic signed [63:0] covariance_out;
    logic        [62:0] variance_x_out;
    logic        [62:0] variance_y_out;
    logic signed [31:0] correlation_out;
    logic        [16:0] pair_count;
    logic        [1:0]  status;
  } out_t;

  typedef struct packed {
    logic       capture;
    logic [2:0] mul_sel;
    logic [1:0] acc_sel;
    logic       div_load;
    logic       div_step;
    logic       div_store;
    logic [1:0] div_sel;
    logic [1:0] rad_op;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       corr_init;
    logic       corr_step;
    logic       set_few;
    logic       set_zero;
    logic       set_corr;
    logic       emit;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic last;
    logic few;
    logic var_zero;
    logic out_busy;
  } stat_t;

endpackage

// ===== hdl/streaming_covariance_correlation.sv =====
// Streaming covariance, variances and correlation with configured means.
// Channels: in (sample pair plus last mark), out (one result per set) and a
// config write port (index 0 mean_x, 1 mean_y, 2 x_population, 3 y_population).
// Config writes are taken every cycle; write them only while the block is idle.
// Each pair is captured, then the shared 33x33 multiplier forms
// the cross product and both squares in turn, each added into a saturating sum.
// Pairs past the count limit are dropped.
// On the last pair of a set the result is formed by bit-serial steps:
// three 64-step divisions, a 4-step radicand build, a 63-step square root and
// a 94-step correlation divide.
// Sets with fewer than two pairs give their result without these steps.
// The result waits in an output register; while the receiver stalls the next
// set is taken in, and the block holds before a new result until the old one
// is transferred.
// Reset clears the sums, count, config registers and the output valid.
// Depends on sccr_pkg, sccr_ctrl and sccr_datapath.
module streaming_covariance_correlation import sccr_pkg::*; #(
  parameter int unsigned MAX_PAIRS = 65536
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_t                in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_t               out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int unsigned CountLimitInt = (MAX_PAIRS < 131071) ? MAX_PAIRS : 131071;
  localparam logic [16:0] CountLimit = 17'(CountLimitInt);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  sccr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sccr_datapath #(
    .COUNT_LIMIT (CountLimit)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== hdl/sccr_ctrl.sv =====
// Sequencer for the covariance / correlation block.
// Drives the datapath by cmd_t and reads back stat_t; depends on sccr_pkg.
module sccr_ctrl import sccr_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ACC0 = 4'd1;
  localparam logic [3:0] S_ACC1 = 4'd2;
  localparam logic [3:0] S_ACC2 = 4'd3;
  localparam logic [3:0] S_ACC3 = 4'd4;
  localparam logic [3:0] S_FIN  = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_DST  = 4'd7;
  localparam logic [3:0] S_CHK  = 4'd8;
  localparam logic [3:0] S_P1   = 4'd9;
  localparam logic [3:0] S_P2   = 4'd10;
  localparam logic [3:0] S_P3   = 4'd11;
  localparam logic [3:0] S_P4   = 4'd12;
  localparam logic [3:0] S_SQ   = 4'd13;
  localparam logic [3:0] S_CR   = 4'd14;
  localparam logic [3:0] S_EMIT = 4'd15;

  localparam logic [6:0] DivLast  = 7'd63;
  localparam logic [6:0] SqrtLast = 7'd62;
  localparam logic [6:0] CorrLast = 7'd93;

  logic [3:0] state, state_next;
  logic [6:0] cnt, cnt_next;
  logic [1:0] dsel, dsel_next;

  assign in_ready = (state == S_IDLE);

  // Advance state, step counter and divider source
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      dsel  <= DIV_CROSS;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      dsel  <= dsel_next;
    end
  end

  // Decode commands and next state
  always_comb begin
    cmd        = '0;
    cmd.mul_sel = MUL_XY;
    cmd.acc_sel = ACC_NONE;
    cmd.rad_op  = RAD_NONE;
    cmd.div_sel = dsel;
    state_next = state;
    cnt_next   = cnt;
    dsel_next  = dsel;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_ACC0;
        end
      end
      S_ACC0: begin
        cmd.mul_sel = MUL_XY;
        if (stat.full) state_next = stat.last ? S_FIN : S_IDLE;
        else state_next = S_ACC1;
      end
      S_ACC1: begin
        cmd.acc_sel = ACC_CROSS;
        cmd.mul_sel = MUL_XX;
        state_next  = S_ACC2;
      end
      S_ACC2: begin
        cmd.acc_sel = ACC_SQX;
        cmd.mul_sel = MUL_YY;
        state_next  = S_ACC3;
      end
      S_ACC3: begin
        cmd.acc_sel = ACC_SQY;
        state_next  = stat.last ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        if (stat.few) begin
          cmd.set_few = 1'b1;
          state_next  = S_EMIT;
        end else begin
          cmd.div_load = 1'b1;
          cmd.div_sel  = DIV_CROSS;
          dsel_next    = DIV_CROSS;
          cnt_next     = '0;
          state_next   = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 7'd1;
        if (cnt == DivLast) state_next = S_DST;
      end
      S_DST: begin
        cmd.div_store = 1'b1;
        cnt_next      = '0;
        if (dsel == DIV_SQY) begin
          state_next = S_CHK;
        end else begin
          cmd.div_load = 1'b1;
          cmd.div_sel  = dsel + 2'd1;
          dsel_next    = dsel + 2'd1;
          state_next   = S_DIV;
          // store uses the current select, load the next one
        end
      end
      S_CHK: begin
        if (stat.var_zero) begin
          cmd.set_zero = 1'b1;
          state_next   = S_EMIT;
        end else begin
          cmd.mul_sel = MUL_P00;
          state_next  = S_P1;
        end
      end
      S_P1: begin
        cmd.rad_op  = RAD_LOAD;
        cmd.mul_sel = MUL_P01;
        state_next  = S_P2;
      end
      S_P2: begin
        cmd.rad_op  = RAD_ADD32;
        cmd.mul_sel = MUL_P10;
        state_next  = S_P3;
      end
      S_P3: begin
        cmd.rad_op  = RAD_ADD32;
        cmd.mul_sel = MUL_P11;
        state_next  = S_P4;
      end
      S_P4: begin
        cmd.rad_op    = RAD_ADD64;
        cmd.sqrt_init = 1'b1;
        cnt_next      = '0;
        state_next    = S_SQ;
      end
      S_SQ: begin
        cmd.sqrt_step = 1'b1;
        cnt_next      = cnt + 7'd1;
        if (cnt == SqrtLast) begin
          cmd.corr_init = 1'b0;
          cnt_next      = '0;
          state_next    = S_CR;
        end
      end
      S_CR: begin
        // init, 94 quotient steps, then latch the finished quotient
        cmd.corr_step = (cnt != '0) && (cnt != CorrLast + 7'd2);
        cmd.corr_init = (cnt == '0);
        cnt_next      = cnt + 7'd1;
        if (cnt == CorrLast + 7'd2) begin
          cmd.set_corr = 1'b1;
          state_next   = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!stat.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== hdl/sccr_datapath.sv =====
// Datapath: deviation capture, shared multiplier, saturating accumulators,
// divider, square root, correlation divider and result register. Uses sccr_pkg.
module sccr_datapath import sccr_pkg::*; #(
  parameter logic [16:0] COUNT_LIMIT = 17'd65536
) (
  input  logic               clk,
  input  logic               rst,
  input  in_t                in_data,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [31:0]        cfg_data,
  input  cmd_t               cmd,
  output stat_t              stat,
  output logic               out_valid,
  input  logic               out_ready,
  output out_t               out_data
);

  logic signed [31:0] mean_x, mean_y;
  logic               pop_x, pop_y;

  logic [32:0] ax, ay;
  logic        dneg, full, last;
  logic [65:0] prod;

  logic signed [63:0] sum_cross;
  logic [63:0]        sum_sqx, sum_sqy;
  logic [16:0]        pairs;

  logic [63:0] dvd;
  logic [17:0] drem;
  logic [16:0] den;
  logic [1:0]  div_dst;

  logic signed [63:0] res_cov;
  logic [62:0]        res_vx, res_vy;
  logic [31:0]        res_corr;
  logic [1:0]         res_status;

  logic [125:0] rad;
  logic [66:0]  srem;
  logic [62:0]  sroot;

  logic [93:0] cm;
  logic [63:0] crem;
  logic [39:0] cq;

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mean_x <= '0;
      mean_y <= '0;
      pop_x  <= 1'b0;
      pop_y  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MEAN_X: mean_x <= cfg_data;
        REG_MEAN_Y: mean_y <= cfg_data;
        REG_X_POP:  pop_x  <= cfg_data[0];
        REG_Y_POP:  pop_y  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Deviations and their magnitudes
  logic signed [32:0] dx, dy;
  assign dx = {in_data.sample_x[31], in_data.sample_x} - {mean_x[31], mean_x};
  assign dy = {in_data.sample_y[31], in_data.sample_y} - {mean_y[31], mean_y};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ax   <= dx[32] ? 33'(-dx) : 33'(dx);
      ay   <= dy[32] ? 33'(-dy) : 33'(dy);
      dneg <= dx[32] ^ dy[32];
      full <= (pairs >= COUNT_LIMIT);
      last <= in_data.last_sample;
    end
  end

  // Shared multiplier operands
  logic [32:0] ma, mb;
  always_comb begin
    unique case (cmd.mul_sel)
      MUL_XY:  begin ma = ax; mb = ay; end
      MUL_XX:  begin ma = ax; mb = ax; end
      MUL_YY:  begin ma = ay; mb = ay; end
      MUL_P00: begin ma = {1'b0, res_vx[31:0]};  mb = {1'b0, res_vy[31:0]};  end
      MUL_P01: begin ma = {1'b0, res_vx[31:0]};  mb = {2'b0, res_vy[62:32]}; end
      MUL_P10: begin ma = {2'b0, res_vx[62:32]}; mb = {1'b0, res_vy[31:0]};  end
      MUL_P11: begin ma = {2'b0, res_vx[62:32]}; mb = {2'b0, res_vy[62:32]}; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= {33'b0, ma} * {33'b0, mb};
  end

  // Saturate product, then saturate the sums
  logic [63:0]        pm;
  logic signed [63:0] term;
  logic [64:0]        cs, us;
  assign pm = (|prod[65:64]) ? {64{1'b1}} : prod[63:0];
  always_comb begin
    if (!dneg) term = pm[63] ? {1'b0, {63{1'b1}}} : pm;
    else term = pm[63] ? {1'b1, 63'b0} : 64'(-pm);
  end
  assign cs = {sum_cross[63], sum_cross} + {term[63], term};
  assign us = {1'b0, (cmd.acc_sel == ACC_SQX) ? sum_sqx : sum_sqy} + {1'b0, pm};

  always_ff @(posedge clk) begin
    if (rst || cmd.emit) begin
      sum_cross <= '0;
      sum_sqx   <= '0;
      sum_sqy   <= '0;
      pairs     <= '0;
    end else begin
      unique case (cmd.acc_sel)
        ACC_CROSS: sum_cross <= (cs[64] != cs[63]) ?
                                (cs[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}}) : cs[63:0];
        ACC_SQX:   sum_sqx <= us[64] ? {64{1'b1}} : us[63:0];
        ACC_SQY: begin
          sum_sqy <= us[64] ? {64{1'b1}} : us[63:0];
          pairs   <= pairs + 17'd1;
        end
        default: ;
      endcase
    end
  end

  // Restoring divider, one quotient bit per cycle
  logic [16:0] n_less;
  logic [17:0] dtry;
  assign n_less = pairs - 17'd1;
  assign dtry   = {drem[16:0], dvd[63]};

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      drem    <= '0;
      div_dst <= cmd.div_sel;
      unique case (cmd.div_sel)
        DIV_CROSS: begin
          dvd <= sum_cross[63] ? 64'(-sum_cross) : sum_cross;
          den <= (pop_x | pop_y) ? pairs : n_less;
        end
        DIV_SQX: begin
          dvd <= sum_sqx;
          den <= pop_x ? pairs : n_less;
        end
        default: begin
          dvd <= sum_sqy;
          den <= pop_y ? pairs : n_less;
        end
      endcase
    end else if (cmd.div_step) begin
      if (dtry >= {1'b0, den}) begin
        drem <= dtry - {1'b0, den};
        dvd  <= {dvd[62:0], 1'b1};
      end else begin
        drem <= dtry;
        dvd  <= {dvd[62:0], 1'b0};
      end
    end
  end

  // Radicand: product of both variances from four partial products
  always_ff @(posedge clk) begin
    unique case (cmd.rad_op)
      RAD_LOAD:  rad <= {60'b0, prod};
      RAD_ADD32: rad <= rad + {28'b0, prod, 32'b0};
      RAD_ADD64: rad <= rad + {prod[61:0], 64'b0};
      default: begin
        if (cmd.sqrt_step) rad <= {rad[123:0], 2'b00};
      end
    endcase
  end

  // Integer square root, one root bit per cycle
  logic [66:0] stry;
  logic [66:0] strial;
  assign stry   = {srem[64:0], rad[125:124]};
  assign strial = {2'b0, sroot, 2'b01};

  always_ff @(posedge clk) begin
    if (cmd.sqrt_init) begin
      srem  <= '0;
      sroot <= '0;
    end else if (cmd.sqrt_step) begin
      if (stry >= strial) begin
        srem  <= stry - strial;
        sroot <= {sroot[61:0], 1'b1};
      end else begin
        srem  <= stry;
        sroot <= {sroot[61:0], 1'b0};
      end
    end
  end

  // Correlation divide: |cov| * 2^30 / root, quotient held to 40 bits
  logic [63:0] cmag, cnr, croot;
  logic [40:0] cqs;
  logic        ctake;
  assign cmag  = res_cov[63] ? 64'(-res_cov) : res_cov;
  assign croot = {1'b0, sroot};
  assign cnr   = {crem[62:0], cm[93]};
  assign ctake = crem[63] || (cnr >= croot);
  assign cqs   = {cq, ctake};

  always_ff @(posedge clk) begin
    if (cmd.corr_init) begin
      cm   <= {cmag, 30'b0};
      crem <= '0;
      cq   <= '0;
    end else if (cmd.corr_step) begin
      cm   <= {cm[92:0], 1'b0};
      crem <= ctake ? cnr - croot : cnr;
      cq   <= cqs[40] ? {40{1'b1}} : cqs[39:0];
    end
  end

  // Final clamp and sign of the correlation
  logic [31:0] corr_val;
  always_comb begin
    if (res_cov[63]) begin
      corr_val = (cq > 40'h80000000) ? 32'h80000000 : 32'(-cq[31:0]);
      if (cq <= 40'h80000000) corr_val = 32'(0 - cq[31:0]);
    end else begin
      corr_val = (cq > 40'h7FFFFFFF) ? 32'h7FFFFFFF : cq[31:0];
    end
  end

  // Result fields; a quotient goes to the field chosen when it was loaded
  always_ff @(posedge clk) begin
    if (cmd.div_store) begin
      unique case (div_dst)
        DIV_CROSS: res_cov <= sum_cross[63] ? 64'(-dvd) : dvd;
        DIV_SQX:   res_vx  <= dvd[63] ? VarMax : dvd[62:0];
        default:   res_vy  <= dvd[63] ? VarMax : dvd[62:0];
      endcase
    end
    if (cmd.set_few) begin
      res_cov    <= '0;
      res_vx     <= '0;
      res_vy     <= '0;
      res_corr   <= '0;
      res_status <= ST_FEW;
    end else if (cmd.set_zero) begin
      res_corr   <= '0;
      res_status <= ST_ZERO_VAR;
    end else if (cmd.set_corr) begin
      res_corr   <= corr_val;
      res_status <= ST_OK;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.covariance_out  <= res_cov;
      out_data.variance_x_out  <= res_vx;
      out_data.variance_y_out  <= res_vy;
      out_data.correlation_out <= res_corr;
      out_data.pair_count      <= pairs;
      out_data.status          <= res_status;
    end
  end

  assign stat.full     = full;
  assign stat.last     = last;
  assign stat.few      = (pairs < 17'd2);
  assign stat.var_zero = (res_vx == '0) || (res_vy == '0);
  assign stat.out_busy = out_valid;

endmodule

// ===== hdl/sccr_checker.sv =====
// Port-level checks for streaming_covariance_correlation, bound to the top.
// Uses sccr_pkg for the payload type and status codes.
module sccr_checker import sccr_pkg::*; (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Clear output after reset
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // Zero correlation whenever status is not ok
  a_corr_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_OK |-> out_data.correlation_out == '0)
    else $error("correlation set on a failed result");

  // Too few pairs means zero statistics and a count below two
  a_few: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_FEW |->
      out_data.pair_count < 17'd2 && out_data.covariance_out == '0 &&
      out_data.variance_x_out == '0 && out_data.variance_y_out == '0)
    else $error("short set result wrong");

endmodule

bind streaming_covariance_correlation sccr_checker u_sccr_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== dv/streaming_covariance_correlation_tb.sv =====
// Testbench for streaming_covariance_correlation: drives sample pairs and
// config writes, predicts each set's statistics and checks every result.
// Depends on sccr_pkg and the RTL of the block.
`timescale 1ns / 1ps

module streaming_covariance_correlation_tb;
  import sccr_pkg::*;

  localparam int unsigned MaxPairs = 65536;
  localparam longint unsigned Low32 = 64'hFFFF_FFFF;
  localparam logic [63:0] Int64Max = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] Int64Min = 64'h8000_0000_0000_0000;

  // Set statistics predictor and store of expected results
  class stats_scoreboard;
    logic signed [63:0] mean_x, mean_y;
    logic x_pop, y_pop;
    logic signed [63:0] cross_sum;
    logic [63:0] sqx_sum, sqy_sum;
    int unsigned pairs;
    out_t pending_results[$];
    int unsigned mismatches;

    function void clear_sums();
      cross_sum = 0;
      sqx_sum = 0;
      sqy_sum = 0;
      pairs = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] data);
      case (idx)
        REG_MEAN_X: mean_x = {{32{data[31]}}, data};
        REG_MEAN_Y: mean_y = {{32{data[31]}}, data};
        REG_X_POP: x_pop = data[0];
        REG_Y_POP: y_pop = data[0];
        default: ;
      endcase
    endfunction

    function logic [63:0] mag(logic signed [63:0] v);
      return v[63] ? -v : v;
    endfunction

    function logic [63:0] mul_mag(logic [63:0] a, logic [63:0] b);
      if (a > Low32 && b > Low32) return '1;
      return a * b;
    endfunction

    function logic signed [63:0] signed_sat(logic [63:0] m, logic neg);
      if (!neg) return (m > Int64Max) ? Int64Max : m;
      if (m >= Int64Min) return Int64Min;
      return -m;
    endfunction

    function logic [63:0] root_of_product(logic [63:0] a, logic [63:0] b);
      logic [127:0] prod, cand2;
      logic [63:0] r, c;
      prod = {64'b0, a} * {64'b0, b};
      r = 0;
      for (int i = 63; i >= 0; i--) begin
        c = r | (64'd1 << i);
        cand2 = {64'b0, c} * {64'b0, c};
        if (cand2 <= prod) r = c;
      end
      return r;
    endfunction

    function logic [31:0] correlation(logic signed [63:0] cov, logic [63:0] root);
      logic [127:0] num, q;
      num = {64'b0, mag(cov)} << 30;
      q = num / {64'b0, root};
      if (cov[63]) begin
        if (q > 128'h8000_0000) q = 128'h8000_0000;
        return -q[31:0];
      end
      if (q > 128'h7FFF_FFFF) q = 128'h7FFF_FFFF;
      return q[31:0];
    endfunction

    // Note one accepted pair; queue a result when it closes the set
    function void note_pair(in_t item);
      logic signed [63:0] dx, dy, cov;
      logic [63:0] ax, ay, s, n, dvx, dvy, dcov, q, vx, vy;
      out_t r;
      if (pairs < MaxPairs) begin
        dx = $signed({{32{item.sample_x[31]}}, item.sample_x}) - mean_x;
        dy = $signed({{32{item.sample_y[31]}}, item.sample_y}) - mean_y;
        ax = mag(dx);
        ay = mag(dy);
        cov = signed_sat(mul_mag(ax, ay), dx[63] != dy[63]);
        s = cross_sum + cov;
        if (!cov[63] && !cross_sum[63] && s[63]) s = Int64Max;
        else if (cov[63] && cross_sum[63] && !s[63]) s = Int64Min;
        cross_sum = s;
        s = sqx_sum + mul_mag(ax, ax);
        sqx_sum = (s < sqx_sum) ? '1 : s;
        s = sqy_sum + mul_mag(ay, ay);
        sqy_sum = (s < sqy_sum) ? '1 : s;
        pairs++;
      end
      if (!item.last_sample) return;
      r = '0;
      n = pairs;
      r.pair_count = n[16:0];
      if (n < 2) begin
        r.status = ST_FEW;
      end else begin
        dvx = x_pop ? n : n - 1;
        dvy = y_pop ? n : n - 1;
        dcov = (x_pop || y_pop) ? n : n - 1;
        q = mag(cross_sum) / dcov;
        cov = cross_sum[63] ? -q : q;
        vx = sqx_sum / dvx;
        if (vx > Int64Max) vx = Int64Max;
        vy = sqy_sum / dvy;
        if (vy > Int64Max) vy = Int64Max;
        r.covariance_out = cov;
        r.variance_x_out = vx[62:0];
        r.variance_y_out = vy[62:0];
        if (vx == 0 || vy == 0) r.status = ST_ZERO_VAR;
        else begin
          r.status = ST_OK;
          r.correlation_out = correlation(cov, root_of_product(vx, vy));
        end
      end
      pending_results.push_back(r);
      clear_sums();
    endfunction

    function void report(string what, logic [63:0] exp_v, logic [63:0] act_v);
      mismatches++;
      if (mismatches <= 10)
        $display("%s mismatch: expected %h actual %h", what, exp_v, act_v);
    endfunction

    // Compare one transferred result with the oldest expectation
    function void check_result(out_t act);
      out_t e;
      if (pending_results.size() == 0) begin
        report("unexpected result", 0, act.pair_count);
        return;
      end
      e = pending_results.pop_front();
      if (act.covariance_out !== e.covariance_out)
        report("covariance", e.covariance_out, act.covariance_out);
      if (act.variance_x_out !== e.variance_x_out)
        report("variance_x", e.variance_x_out, act.variance_x_out);
      if (act.variance_y_out !== e.variance_y_out)
        report("variance_y", e.variance_y_out, act.variance_y_out);
      if (act.correlation_out !== e.correlation_out)
        report("correlation", e.correlation_out, act.correlation_out);
      if (act.pair_count !== e.pair_count)
        report("pair_count", e.pair_count, act.pair_count);
      if (act.status !== e.status) report("status", e.status, act.status);
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0, in_ready;
  in_t in_data = '0;
  logic out_valid, out_ready = 0;
  out_t out_data;
  logic cfg_valid = 0, cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  stats_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 0;

  always #1 clk = ~clk;

  streaming_covariance_correlation #(.MAX_PAIRS(MaxPairs)) dut (.*);

  // Watch transfers on both channels
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) sb.note_pair(in_data);
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_off) out_ready <= 0;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Offer one config write and hold it until transferred; the caller drops valid
  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [31:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  // Offer one pair after a random gap; hold until transferred
  task automatic send_pair(logic [31:0] x, logic [31:0] y, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data <= '{sample_x: x, sample_y: y, last_sample: last};
    do @(posedge clk); while (!in_ready);
  endtask

  // Wait for every expected result, then let a final division drain
  task automatic drain();
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_sample(logic [31:0] mean);
    case ($urandom_range(5))
      0: return $urandom;
      1: return mean + $urandom_range(65535) - 32768;
      2: return {$urandom_range(1) ? 1'b1 : 1'b0, 31'h0};
      3: return mean;
      default: return mean + (($urandom & 32'h00FF_FFFF) - 32'h0080_0000);
    endcase
  endfunction

  task automatic random_sets(int unsigned items);
    int unsigned sent, len;
    logic [31:0] xv, yv;
    sent = 0;
    while (sent < items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(1, 3) : $urandom_range(2, 40);
      for (int k = 0; k < len; k++) begin
        xv = rand_sample(sb.mean_x);
        yv = ($urandom_range(3) == 0) ? xv : rand_sample(sb.mean_y);
        send_pair(xv, yv, k == len - 1);
        sent++;
      end
    end
    in_valid <= 0;
  endtask

  task automatic set_config(logic [31:0] mx, logic [31:0] my, logic xp, logic yp);
    cfg_write(REG_MEAN_X, mx);
    cfg_write(REG_MEAN_Y, my);
    cfg_write(REG_X_POP, {31'b0, xp});
    cfg_write(REG_Y_POP, {31'b0, yp});
    cfg_valid <= 0;
  endtask

  initial begin
    sb.mean_x = 0;
    sb.mean_y = 0;
    sb.x_pop = 0;
    sb.y_pop = 0;
    sb.mismatches = 0;
    sb.clear_sums();
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: single pair, extremes, zero variance, saturation
    send_pair(32'h0001_0000, 32'h0002_0000, 1);
    send_pair(32'h7FFF_FFFF, 32'h8000_0000, 0);
    send_pair(32'h8000_0000, 32'h7FFF_FFFF, 1);
    send_pair(32'h0000_5000, 32'h1234_0000, 0);
    send_pair(32'h0000_5000, 32'hFFFF_0000, 1);
    send_pair(32'h8000_0000, 32'h8000_0000, 0);
    send_pair(32'h8000_0000, 32'h8000_0000, 0);
    send_pair(32'h8000_0000, 32'h8000_0000, 1);
    send_pair(32'h0003_0000, 32'hFFFD_0000, 0);
    send_pair(32'hFFFD_0000, 32'h0003_0000, 1);
    in_valid <= 0;
    drain();
    // Extreme means make deviations of magnitude 2^32-1 and saturated sums
    set_config(32'h7FFF_FFFF, 32'h8000_0000, 1, 0);
    send_pair(32'h8000_0000, 32'h7FFF_FFFF, 0);
    send_pair(32'h8000_0000, 32'h7FFF_FFFF, 0);
    send_pair(32'h8000_0000, 32'h7FFF_FFFF, 1);
    send_pair(32'h8000_0000, 32'h8000_0000, 0);
    send_pair(32'h1000_0000, 32'h8000_0000, 1);
    in_valid <= 0;
    drain();
    set_config(32'h8000_0000, 32'h7FFF_FFFF, 0, 1);
    send_pair(32'h7FFF_FFFF, 32'h8000_0000, 0);
    send_pair(32'h0000_0001, 32'h0000_0000, 1);
    in_valid <= 0;
    drain();
    cfg_write(4, 32'hFFFF_FFFF);
    cfg_write(7, 32'h1234_5678);
    cfg_valid <= 0;

    // Random phases under varied idling and settings
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      set_config($urandom, ($urandom_range(1) ? 32'h0 : $urandom),
                 $urandom_range(1), $urandom_range(1));
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 73; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 73; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      if (ph == 2) begin
        fork
          begin
            hold_off = 1;
            repeat (3000) @(posedge clk);
            hold_off = 0;
          end
          random_sets(225);
        join
      end else random_sets(225);
    end
    drain();

    if (sb.mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end
endmodule
